[hdl/rfc_pkg.sv]
// Shared constants, codes and record types of the radio frame checker.
package rfc_pkg;

  localparam int HDR_BYTES = 8;
  localparam int MAX_PAYLOAD = 32;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [7:0] OVER_AT = 8'(HDR_BYTES + MAX_PAYLOAD);
  localparam logic [7:0] HDR_END = 8'(HDR_BYTES);
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [5:0] MAX_LEN = 6'(MAX_PAYLOAD);

  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_LONG    = 3'd2,
    ST_BAD_SUM = 3'd3,
    ST_BAD_VER = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  version;
    logic [5:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [7:0]  sequence_res;
    logic [7:0]  ack_sequence;
    logic [15:0] ack_bitmap;
    logic [7:0]  hop_index;
    logic [7:0]  epoch_low;
    logic [5:0]  payload_length;
    status_t     status;
  } verdict_t;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] data_byte;
    logic       has_verdict;
    verdict_t   verdict;
  } rec_t;

endpackage

[hdl/rfc_in_if.sv]
// Input byte channel of the radio frame checker.
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

[hdl/rfc_cfg_if.sv]
// Configuration write channel carrying the expected version.
interface rfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/rfc_out_if.sv]
// Result channel of the radio frame checker.
interface rfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  version;
  logic [5:0]  msg_type;
  logic [7:0]  flag_bits;
  logic [7:0]  sequence_res;
  logic [7:0]  ack_sequence;
  logic [15:0] ack_bitmap;
  logic [7:0]  hop_index;
  logic [7:0]  epoch_low;
  logic [5:0]  payload_length;
  logic [2:0]  status;

  modport source (
    output valid, output kind, output data_byte, output version, output msg_type,
    output flag_bits, output sequence_res, output ack_sequence, output ack_bitmap,
    output hop_index, output epoch_low, output payload_length, output status,
    input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input version, input msg_type,
    input flag_bits, input sequence_res, input ack_sequence, input ack_bitmap,
    input hop_index, input epoch_low, input payload_length, input status,
    output ready
  );
endinterface

[hdl/radio_frame_checker_unit.sv]
// Top level of the radio frame checker: front end, record queue and back end.
//
//   Channel  Direction  Carries
//   rx       in         rx_byte, last_byte: one raw frame byte per item
//   cfg      in         data: expected protocol version
//   res      out        kind, data_byte, unpacked header, payload_length, status
//
// The front end takes one byte item per cycle while the four-entry record queue has room.
// The last byte of a frame yields a record that the back end sends as up to two items, back to
// back unless the result channel stalls; header bytes yield none, so the queue absorbs the burst.
// Reset is synchronous and active high; the expected version resets to one.
// A stalled result holds in the output register while input bytes keep filling the queue.
module radio_frame_checker_unit (
  input  logic      clk,
  input  logic      rst,
  rfc_in_if.sink    rx,
  rfc_cfg_if.sink   cfg,
  rfc_out_if.source res
);
  import rfc_pkg::*;

  logic q_not_full;
  logic q_empty;
  logic push;
  logic pop;
  rec_t push_rec;
  rec_t head;

  rfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg      (cfg),
    .q_ready  (q_not_full),
    .push     (push),
    .push_rec (push_rec)
  );

  rfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .not_full (q_not_full),
    .empty    (q_empty),
    .head     (head)
  );

  rfc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (head),
    .pop   (pop),
    .res   (res)
  );

endmodule

[hdl/rfc_front.sv]
// Front end: frame state tracking and per-item classification into queue records.
module rfc_front (
  input  logic         clk,
  input  logic         rst,
  rfc_in_if.sink       rx,
  rfc_cfg_if.sink      cfg,
  input  logic         q_ready,
  output logic         push,
  output rfc_pkg::rec_t push_rec
);
  import rfc_pkg::*;

  logic [7:0] byte_count;
  logic [7:0] running_sum;
  logic [7:0] held_byte;
  logic [7:0] header_store [HDR_BYTES];
  logic       overlength;
  logic [1:0] expected_version;

  logic       accept;
  logic       emit;
  logic [1:0] ver;
  status_t    st;
  logic [5:0] plen;
  logic [7:0] body_count;

  assign rx.ready  = q_ready;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && q_ready;

  assign emit       = (byte_count > HDR_END) && !overlength;
  assign ver        = header_store[0][7:6];
  assign body_count = byte_count - HDR_END;

  always_comb begin
    if (byte_count < HDR_END) begin
      st   = ST_SHORT;
      plen = 6'd0;
    end else if (overlength) begin
      st   = ST_LONG;
      plen = MAX_LEN;
    end else begin
      plen = body_count[5:0];
      if (running_sum != rx.rx_byte) begin
        st = ST_BAD_SUM;
      end else if (ver != expected_version) begin
        st = ST_BAD_VER;
      end else begin
        st = ST_OK;
      end
    end
  end

  assign push = accept && (emit || rx.last_byte);

  always_comb begin
    push_rec.has_payload            = emit;
    push_rec.data_byte              = held_byte;
    push_rec.has_verdict            = rx.last_byte;
    push_rec.verdict.version        = ver;
    push_rec.verdict.msg_type       = header_store[0][5:0];
    push_rec.verdict.flag_bits      = header_store[1];
    push_rec.verdict.sequence_res   = header_store[2];
    push_rec.verdict.ack_sequence   = header_store[3];
    push_rec.verdict.ack_bitmap     = {header_store[5], header_store[4]};
    push_rec.verdict.hop_index      = header_store[6];
    push_rec.verdict.epoch_low      = header_store[7];
    push_rec.verdict.payload_length = plen;
    push_rec.verdict.status         = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      running_sum      <= '0;
      overlength       <= 1'b0;
      expected_version <= 2'd1;
      for (int i = 0; i < HDR_BYTES; i++) begin
        header_store[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        expected_version <= cfg.data;
      end
      if (accept) begin
        if (rx.last_byte) begin
          byte_count  <= '0;
          running_sum <= '0;
          overlength  <= 1'b0;
          for (int i = 0; i < HDR_BYTES; i++) begin
            header_store[i] <= '0;
          end
        end else begin
          if (byte_count < HDR_END) begin
            header_store[byte_count[HDR_IDX_W-1:0]] <= rx.rx_byte;
          end else if (byte_count >= OVER_AT) begin
            overlength <= 1'b1;
          end
          running_sum <= running_sum + rx.rx_byte;
          if (byte_count != COUNT_MAX) begin
            byte_count <= byte_count + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !rx.last_byte && byte_count >= HDR_END) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

[hdl/rfc_queue.sv]
// Short record queue between the front end and the back end.
module rfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfc_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          not_full,
  output logic          empty,
  output rfc_pkg::rec_t head
);
  import rfc_pkg::*;

  rec_t              slots [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign not_full = fill != QCNT_W'(QDEPTH);
  assign empty    = fill == '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

[hdl/rfc_back.sv]
// Back end: expands queue records into payload and verdict items on the output register.
module rfc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  rfc_pkg::rec_t head,
  output logic          pop,
  rfc_out_if.source     res
);
  import rfc_pkg::*;

  logic verdict_phase;
  logic load;
  logic send_payload;

  assign load         = !empty && (!res.valid || res.ready);
  assign send_payload = head.has_payload && !verdict_phase;
  assign pop          = load && !(send_payload && head.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid     <= 1'b0;
      verdict_phase <= 1'b0;
    end else begin
      if (load) begin
        res.valid     <= 1'b1;
        verdict_phase <= send_payload && head.has_verdict;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_payload) begin
        res.kind           <= KIND_PAYLOAD;
        res.data_byte      <= head.data_byte;
        res.version        <= '0;
        res.msg_type       <= '0;
        res.flag_bits      <= '0;
        res.sequence_res   <= '0;
        res.ack_sequence   <= '0;
        res.ack_bitmap     <= '0;
        res.hop_index      <= '0;
        res.epoch_low      <= '0;
        res.payload_length <= '0;
        res.status         <= '0;
      end else begin
        res.kind           <= KIND_VERDICT;
        res.data_byte      <= '0;
        res.version        <= head.verdict.version;
        res.msg_type       <= head.verdict.msg_type;
        res.flag_bits      <= head.verdict.flag_bits;
        res.sequence_res   <= head.verdict.sequence_res;
        res.ack_sequence   <= head.verdict.ack_sequence;
        res.ack_bitmap     <= head.verdict.ack_bitmap;
        res.hop_index      <= head.verdict.hop_index;
        res.epoch_low      <= head.verdict.epoch_low;
        res.payload_length <= head.verdict.payload_length;
        res.status         <= head.verdict.status;
      end
    end
  end

endmodule
